// ===== hdl/heat_diffusion_stencil_2d_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heat diffusion stencil unit
// Shared property wrappers clocked on the unit's clock; one is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_2D_UNIT_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_2D_UNIT_ASSERT_SVH

// Checked only outside reset.
`define HDST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define HDST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/hdst_pkg.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion stencil package
// Fixed widths, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package hdst_pkg;

   localparam int SampleBits = 32;
   localparam int LenBits    = 11;
   localparam int RowBits    = 16;
   localparam int GainBits   = 15;
   localparam int GainShift  = 16;

   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 16;

   localparam logic [CsrIdxBits-1:0] CsrRowLength     = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrRowCount      = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrDiffusionGain = 2'd2;

   localparam logic [LenBits-1:0]  MinRowLength = 11'd3;
   localparam logic [RowBits-1:0]  MinRowCount  = 16'd3;
   localparam logic [RowBits-1:0]  ResetRowCount = 16'd512;
   localparam logic [GainBits-1:0] GainLimit    = 15'd16384;

   typedef logic signed [SampleBits-1:0] sample_type;

   typedef struct packed {
      logic [LenBits-1:0]  row_length;
      logic [RowBits-1:0]  row_count;
      logic [GainBits-1:0] diffusion_gain;
   } cfg_type;

endpackage

// ===== hdl/hdst_csr.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Clamps written values to their usable ranges and flags a sweep restart.
// ----------------------------------------------------------------------------
module hdst_csr #(
   parameter int MaxCols = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [hdst_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [hdst_pkg::CsrDataBits-1:0] csr_data,
   output hdst_pkg::cfg_type                cfg,
   output logic                             restart
);
   import hdst_pkg::*;

   localparam logic [LenBits-1:0] ResetRowLength =
      (MaxCols < 512) ? LenBits'(MaxCols) : 11'd512;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                restart_in;
   logic [LenBits-1:0]  len_wr;
   logic [RowBits-1:0]  rows_wr;
   logic [GainBits-1:0] gain_wr;

   always_comb begin
      len_wr = csr_data[LenBits-1:0];
      if (len_wr < MinRowLength) begin
         len_wr = MinRowLength;
      end else if (int'(len_wr) > MaxCols) begin
         len_wr = LenBits'(MaxCols);
      end

      rows_wr = csr_data[RowBits-1:0];
      if (rows_wr < MinRowCount) begin
         rows_wr = MinRowCount;
      end

      gain_wr = csr_data[GainBits-1:0];
      if (gain_wr > GainLimit) begin
         gain_wr = GainLimit;
      end

      cfg_in     = cfg_ff;
      restart_in = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CsrRowLength: begin
               cfg_in.row_length = len_wr;
               restart_in        = 1'b1;
            end
            CsrRowCount: begin
               cfg_in.row_count = rows_wr;
               restart_in       = 1'b1;
            end
            CsrDiffusionGain: begin
               cfg_in.diffusion_gain = gain_wr;
               restart_in            = 1'b1;
            end
            default: begin
               cfg_in     = cfg_ff;
               restart_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_length     <= ResetRowLength;
         cfg_ff.row_count      <= ResetRowCount;
         cfg_ff.diffusion_gain <= GainLimit;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = restart_in;

endmodule

// ===== hdl/hdst_line_buffer.sv =====
// ----------------------------------------------------------------------------
// Line buffer
// Two row stores; reads the centre, east and north cells of the next cell.
// ----------------------------------------------------------------------------
module hdst_line_buffer #(
   parameter int MaxCols = 1024
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [$clog2(MaxCols)-1:0]  rd_col,
   input  logic                        wr_en,
   input  logic [$clog2(MaxCols)-1:0]  wr_col,
   input  hdst_pkg::sample_type        wr_cell,
   input  hdst_pkg::sample_type        wr_center,
   output hdst_pkg::sample_type        center,
   output hdst_pkg::sample_type        east,
   output hdst_pkg::sample_type        north
);
   import hdst_pkg::*;

   localparam int ColBits = $clog2(MaxCols);

   sample_type prev_row_ff [MaxCols];
   sample_type second_row_ff [MaxCols];
   sample_type center_ff;
   sample_type east_ff;
   sample_type north_ff;
   logic [ColBits-1:0] east_col;

   // Wraps to zero past the end of the store; that read is masked downstream.
   assign east_col = rd_col + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prev_row_ff[wr_col]   <= wr_cell;
         second_row_ff[wr_col] <= wr_center;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         center_ff <= prev_row_ff[rd_col];
         east_ff   <= prev_row_ff[east_col];
         north_ff  <= second_row_ff[rd_col];
      end
   end

   assign center = center_ff;
   assign east   = east_ff;
   assign north  = north_ff;

endmodule

// ===== hdl/hdst_update.sv =====
// ----------------------------------------------------------------------------
// Stencil update
// Five-point Laplacian, gain multiply, floor shift and saturating add.
// ----------------------------------------------------------------------------
module hdst_update (
   input  hdst_pkg::sample_type               center,
   input  hdst_pkg::sample_type               north,
   input  hdst_pkg::sample_type               south,
   input  hdst_pkg::sample_type               east,
   input  hdst_pkg::sample_type               west,
   input  logic [hdst_pkg::GainBits-1:0]      gain,
   input  logic                               pass,
   output hdst_pkg::sample_type               value
);
   import hdst_pkg::*;

   localparam int LapBits  = SampleBits + 4;
   localparam int ProdBits = LapBits + GainBits + 1;
   localparam int SumBits  = LapBits + 1;

   logic signed [LapBits-1:0]  lap;
   logic signed [GainBits:0]   gain_s;
   logic signed [ProdBits-1:0] prod;
   logic signed [ProdBits-1:0] prod_shr;
   logic signed [LapBits-1:0]  delta;
   logic signed [SumBits-1:0]  sum;
   logic                       overflow;
   sample_type                 sat;

   always_comb begin
      lap = LapBits'(north) + LapBits'(south) + LapBits'(east) + LapBits'(west)
            - (LapBits'(center) <<< 2);
      gain_s   = $signed({1'b0, gain});
      prod     = lap * gain_s;
      // Arithmetic shift floors, matching the reference rounding.
      prod_shr = prod >>> GainShift;
      delta    = prod_shr[LapBits-1:0];
      sum      = SumBits'(center) + SumBits'(delta);

      // The sum fits when every bit above the sample's sign bit agrees with it.
      overflow = (sum[SumBits-1:SampleBits-1] != '0) &&
                 (sum[SumBits-1:SampleBits-1] != '1);
      if (!overflow) begin
         sat = sum[SampleBits-1:0];
      end else if (sum[SumBits-1]) begin
         sat = {1'b1, {(SampleBits-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SampleBits-1){1'b1}}};
      end

      value = pass ? center : sat;
   end

endmodule

// ===== hdl/heat_diffusion_stencil_2d_unit.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion stencil unit
// One explicit five-point Jacobi sweep over a raster stream of Q1.30 cells.
//
// Cells enter on the req_ channel in raster order, row_length cells per row
// and row_count rows per sweep. Updated cells leave on the rsp_ channel one
// row behind: each input of row r gives the updated cell of row r-1 in the
// same column; the first row gives nothing and the last row gives two
// results per input (the row above, then the input itself as an edge cell).
// The input stage registers the row store read with the cell, and the output
// register then takes the result on to rsp_. One cell is taken per clock while
// the receiver does not stall; on the last row each cell gives two results,
// so the next cell waits until the second is loaded. The rate is set
// by the single input stage, which is freed as the output register takes its
// last result, so a stalled receiver holds the output and then the input.
// Reset clears the positions and control state and loads row_length 512
// (MaxCols if smaller), row_count 512 and gain 16384; the row stores need no
// clearing. A csr_ write to a mapped index restarts at row 0, column 0.
// ----------------------------------------------------------------------------
`include "heat_diffusion_stencil_2d_unit_assert.svh"

module heat_diffusion_stencil_2d_unit #(
   parameter int MaxCols = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hdst_pkg::sample_type             req_cell_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hdst_pkg::sample_type             rsp_new_value,
   output logic                             rsp_last_of_item,
   output logic                             rsp_end_of_sweep,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hdst_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [hdst_pkg::CsrDataBits-1:0] csr_data
);
   import hdst_pkg::*;

   localparam int ColBits = $clog2(MaxCols);
   localparam int CmpBits = (ColBits > LenBits) ? ColBits : LenBits;

   cfg_type cfg;
   logic    restart;

   // Raster position of the next input.
   logic [ColBits-1:0] col_pos_ff, col_pos_in;
   logic [RowBits-1:0] row_pos_ff, row_pos_in;
   logic [CmpBits-1:0] col_ext, len_ext;
   logic               at_last_col;
   logic               at_last_row;

   // Input stage.
   logic               s1_valid_ff, s1_valid_in;
   logic               phase_ff, phase_in;
   sample_type         s1_cell_ff;
   logic [ColBits-1:0] s1_col_ff;
   logic               s1_has_a_ff, s1_pass_ff, s1_has_b_ff, s1_last_col_ff;
   sample_type         west_ff, west_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_value_ff, rsp_value_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_eos_ff, rsp_eos_in;

   logic       accept;
   logic       out_free;
   logic       out_load;
   logic       emit_a;
   logic       last_emit;
   logic       s1_done;

   sample_type center, east_raw, east, north, updated;

   hdst_csr #(
      .MaxCols (MaxCols)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (restart)
   );

   hdst_line_buffer #(
      .MaxCols (MaxCols)
   ) u_line_buffer (
      .clock     (clock),
      .rd_en     (accept),
      .rd_col    (col_pos_ff),
      .wr_en     (s1_done),
      .wr_col    (s1_col_ff),
      .wr_cell   (s1_cell_ff),
      .wr_center (center),
      .center    (center),
      .east      (east_raw),
      .north     (north)
   );

   // The east neighbour past the row's end is zero; it is never used there.
   assign east = s1_last_col_ff ? '0 : east_raw;

   hdst_update u_update (
      .center (center),
      .north  (north),
      .south  (s1_cell_ff),
      .east   (east),
      .west   (west_ff),
      .gain   (cfg.diffusion_gain),
      .pass   (s1_pass_ff),
      .value  (updated)
   );

   assign col_ext     = CmpBits'(col_pos_ff);
   assign len_ext     = CmpBits'(cfg.row_length);
   assign at_last_col = (col_ext == len_ext - 1'b1);
   assign at_last_row = (row_pos_ff == cfg.row_count - 1'b1);

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit_a    = !phase_ff && s1_has_a_ff;
      last_emit = !(s1_has_a_ff && s1_has_b_ff && !phase_ff);
      out_load  = s1_valid_ff && (s1_has_a_ff || s1_has_b_ff) && out_free;
      // A first-row transaction makes no result and leaves at once.
      s1_done   = s1_valid_ff &&
                  ((!s1_has_a_ff && !s1_has_b_ff) || (out_load && last_emit));
      req_stall = s1_valid_ff && !s1_done;
      accept    = req_valid && !req_stall;

      s1_valid_in = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
      if (out_load && !last_emit) begin
         phase_in = 1'b1;
      end else if (s1_done) begin
         phase_in = 1'b0;
      end else begin
         phase_in = phase_ff;
      end

      west_in = s1_done ? center : west_ff;

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (restart) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_pos_in = '0;
            row_pos_in = at_last_row ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eos_in   = rsp_eos_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (emit_a) begin
            rsp_value_in = updated;
            rsp_last_in  = !s1_has_b_ff;
            rsp_eos_in   = 1'b0;
         end else begin
            rsp_value_in = s1_cell_ff;
            rsp_last_in  = 1'b1;
            rsp_eos_in   = s1_last_col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         west_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         west_ff      <= west_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff     <= req_cell_value;
         s1_col_ff      <= col_pos_ff;
         s1_has_a_ff    <= (row_pos_ff != '0);
         s1_pass_ff     <= (row_pos_ff == RowBits'(1)) || (col_pos_ff == '0) || at_last_col;
         s1_has_b_ff    <= at_last_row;
         s1_last_col_ff <= at_last_col;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_eos_ff   <= rsp_eos_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_value    = rsp_value_ff;
   assign rsp_last_of_item = rsp_last_ff;
   assign rsp_end_of_sweep = rsp_eos_ff;
   assign csr_ready        = 1'b1;

   `HDST_ASSERT(a_no_overwrite, (rsp_valid_ff && rsp_stall) |-> !out_load, "held result overwritten")
   `HDST_ASSERT(a_phase_two_results, phase_ff |-> (s1_valid_ff && s1_has_a_ff && s1_has_b_ff), "second phase without two results")
   `HDST_ASSERT(a_col_in_row, col_ext < len_ext, "column position beyond row length")
   `HDST_ASSERT(a_eos_is_last, (rsp_valid && rsp_end_of_sweep) |-> rsp_last_of_item, "end of sweep on a non-final result")
   `HDST_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp_valid, "result valid after reset")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil unit testbench
// Streams grids of cells through the unit under several register settings and
// idle patterns on both sides. Each transaction is also run through a
// predictor of the Jacobi sweep, and every result that leaves the unit is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
   import hdst_pkg::*;

   localparam logic [CsrIdxBits-1:0] CsrUnmapped = 2'd3;
   localparam int          LineDepth      = 1024;
   localparam int unsigned ResetRowLength = 512;
   localparam int          SettleCycles   = 8;
   localparam int          HoldCycles     = 300;
   localparam int          RandomCells    = 350;
   localparam longint      SampleMax      = (longint'(1) <<< (SampleBits - 1)) - 1;
   localparam longint      SampleMin      = -SampleMax - 1;
   localparam sample_type  CellMax        = {1'b0, {(SampleBits - 1){1'b1}}};
   localparam sample_type  CellMin        = {1'b1, {(SampleBits - 1){1'b0}}};

   typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_type;
   typedef enum int {CellsWide, CellsExtreme, CellsSmooth} cell_style_type;

   typedef struct {
      sample_type value;
      logic       last_of_item;
      logic       end_of_sweep;
   } cell_result_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   sample_type             req_cell_value   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   sample_type             rsp_new_value;
   logic                   rsp_last_of_item;
   logic                   rsp_end_of_sweep;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxBits-1:0]  csr_index        = '0;
   logic [CsrDataBits-1:0] csr_data         = '0;

   // Predictor state: the two line stores, the raster position and the settings.
   sample_type  line_above     [LineDepth];
   sample_type  line_two_above [LineDepth];
   sample_type  west_prev      = '0;
   int unsigned sweep_col      = 0;
   int unsigned sweep_row      = 0;
   int unsigned row_len        = ResetRowLength;
   int unsigned row_total      = ResetRowCount;
   int unsigned gain_q16       = GainLimit;

   cell_result_type expected_cells [$];
   int              error_count = 0;
   int              cells_sent  = 0;

   bit              sender_bursts = 1'b0;
   int              burst_left    = 0;
   stall_mode_type  stall_mode    = StallNone;
   logic [15:0]     stall_pattern = '0;
   logic [3:0]      stall_tick    = '0;
   bit              hold_request  = 1'b0;
   int              hold_left     = 0;

   heat_diffusion_stencil_2d_unit #(
      .MaxCols(LineDepth)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_new_value   (rsp_new_value),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_end_of_sweep(rsp_end_of_sweep),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Works out the results caused by one accepted cell and advances the sweep.
   function automatic void predict_relaxed_cells(input sample_type cell_val);
      int unsigned c;
      int unsigned r;
      sample_type  mid;
      sample_type  north;
      sample_type  east;
      sample_type  updated;
      longint      lap;
      longint      sum;
      c     = sweep_col;
      r     = sweep_row;
      mid   = line_above[c];
      north = line_two_above[c];
      east  = (c + 1 < row_len) ? line_above[c + 1] : '0;
      if (r >= 1) begin
         updated = mid;
         if (r != 1 && c != 0 && c != row_len - 1) begin
            lap = longint'(north) + longint'(cell_val) + longint'(east) + longint'(west_prev)
                  - 4 * longint'(mid);
            // Shifting the whole product floors it, which is the rounding wanted.
            sum = longint'(mid) + ((lap * longint'(gain_q16)) >>> GainShift);
            if (sum > SampleMax) begin
               sum = SampleMax;
            end else if (sum < SampleMin) begin
               sum = SampleMin;
            end
            updated = sample_type'(sum);
         end
         expected_cells.push_back('{updated, r != row_total - 1, 1'b0});
      end
      if (r == row_total - 1) begin
         expected_cells.push_back('{cell_val, 1'b1, c == row_len - 1});
      end
      line_two_above[c] = mid;
      line_above[c]     = cell_val;
      west_prev         = mid;
      c++;
      if (c >= row_len) begin
         c = 0;
         r++;
         if (r >= row_total) begin
            r = 0;
         end
      end
      sweep_col = c;
      sweep_row = r;
   endfunction

   task automatic send_cell(input sample_type cell_val);
      if (sender_bursts && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid      <= 1'b1;
      req_cell_value <= cell_val;
      do @(posedge clock); while (req_stall);
      predict_relaxed_cells(cell_val);
      cells_sent++;
   endtask

   task automatic send_cells(input int count, input cell_style_type style);
      sample_type base;
      sample_type cell_val;
      base = sample_type'($urandom);
      for (int i = 0; i < count; i++) begin
         case (style)
            CellsExtreme: begin
               case ($urandom_range(0, 3))
                  0:       cell_val = CellMax;
                  1:       cell_val = CellMin;
                  2:       cell_val = '0;
                  default: cell_val = '1;
               endcase
            end
            CellsSmooth: cell_val = base + sample_type'($urandom_range(0, 4095)) - 2048;
            default:     cell_val = sample_type'($urandom);
         endcase
         send_cell(cell_val);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   // A first-row cell leaves nothing to wait for, so allow the pipeline to empty.
   task automatic settle_block();
      drain_results();
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIdxBits-1:0]  idx,
                                 input logic [CsrDataBits-1:0] value);
      int unsigned v;
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CsrRowLength: begin
            v = value[LenBits-1:0];
            if (v < MinRowLength) v = MinRowLength;
            if (v > LineDepth) v = LineDepth;
            row_len = v;
         end
         CsrRowCount: begin
            v = value[RowBits-1:0];
            if (v < MinRowCount) v = MinRowCount;
            row_total = v;
         end
         CsrDiffusionGain: begin
            v = value[GainBits-1:0];
            if (v > GainLimit) v = GainLimit;
            gain_q16 = v;
         end
         default: return;
      endcase
      sweep_col = 0;
      sweep_row = 0;
   endtask

   task automatic configure(input int unsigned len, input int unsigned rows,
                            input int unsigned gain);
      write_register(CsrRowLength, 16'(len));
      write_register(CsrRowCount, 16'(rows));
      write_register(CsrDiffusionGain, 16'(gain));
   endtask

   task automatic set_idling(input bit bursts, input stall_mode_type mode);
      sender_bursts = bursts;
      burst_left    = 0;
      stall_mode    = mode;
      // Bits 0 and 8 are kept clear so that a stall run never spans bit 0 or bit 8 of the pattern.
      stall_pattern = 16'($urandom) & 16'hFEFE;
   endtask

   // Receiver: a long hold when asked for, otherwise the current stall mode.
   always @(posedge clock) begin
      stall_tick = stall_tick + 1'b1;
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            StallRandom:  rsp_stall <= ($urandom_range(0, 3) == 0);
            StallPattern: rsp_stall <= stall_pattern[stall_tick];
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : result_checker
      cell_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: result %h arrived with nothing expected", $time, rsp_new_value);
            error_count++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_new_value !== want.value) begin
               $display("%0t: new_value expected %h actual %h",
                        $time, want.value, rsp_new_value);
               error_count++;
            end
            if (rsp_last_of_item !== want.last_of_item) begin
               $display("%0t: last_of_item expected %b actual %b",
                        $time, want.last_of_item, rsp_last_of_item);
               error_count++;
            end
            if (rsp_end_of_sweep !== want.end_of_sweep) begin
               $display("%0t: end_of_sweep expected %b actual %b",
                        $time, want.end_of_sweep, rsp_end_of_sweep);
               error_count++;
            end
         end
      end
   end

   // Reset settings: a row of 512 cells and four more, then rows of three cells with the reset gain.
   task automatic test_reset_defaults();
      set_idling(1'b0, StallNone);
      send_cells(ResetRowLength + 4, CellsWide);
      write_register(CsrRowLength, 16'd3);
      send_cells(3 * 3 + 1, CellsSmooth);
   endtask

   // Two back-to-back 3x3 sweeps: a cold centre among hot cells, then the reverse.
   task automatic test_cell_extremes();
      configure(3, 3, GainLimit);
      for (int i = 0; i < 18; i++) begin
         if ((i % 9 == 4) == (i < 9)) begin
            send_cell(CellMin);
         end else begin
            send_cell(CellMax);
         end
      end
   endtask

   task automatic test_register_limits();
      set_idling(1'b1, StallRandom);
      configure(0, 1, 16'hFFFF);
      send_cells(9, CellsWide);
      // Bit 11 of the row length lies outside the register and is dropped.
      configure(16'h0802, 2, 16'h4001);
      send_cells(9, CellsSmooth);
      configure(4, 4, 0);
      send_cells(16, CellsSmooth);
      write_register(CsrUnmapped, 16'hFFFF);
      send_cells(16, CellsWide);
      write_register(CsrDiffusionGain, 16'd1);
      send_cells(16, CellsSmooth);
   endtask

   task automatic test_back_pressure();
      set_idling(1'b0, StallNone);
      configure(5, 4, GainLimit);
      hold_request = 1'b1;
      send_cells(30, CellsWide);
      // The sender now waits for every outstanding result before going on.
      drain_results();
      send_cells(30, CellsSmooth);
   endtask

   task automatic test_restart_mid_sweep();
      set_idling(1'b1, StallPattern);
      configure(6, 5, $urandom_range(0, GainLimit));
      send_cells(15, CellsSmooth);
      write_register(CsrDiffusionGain, 16'($urandom_range(0, GainLimit)));
      send_cells(30, CellsSmooth);
      send_cells(10, CellsSmooth);
      write_register(CsrRowLength, 16'd4);
      send_cells(20, CellsSmooth);
   endtask

   task automatic test_random_sweeps();
      int          first;
      int unsigned len;
      int unsigned rows;
      int unsigned gain;
      int          total;
      first = cells_sent;
      while (cells_sent - first < RandomCells) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
         rows = (len > 12) ? 3 : $urandom_range(3, 8);
         case ($urandom_range(0, 3))
            0:       gain = GainLimit;
            1:       gain = 0;
            2:       gain = $urandom_range(0, GainLimit);
            default: gain = $urandom_range(0, 32767);
         endcase
         configure(len, rows, gain);
         set_idling($urandom_range(0, 3) != 0, stall_mode_type'($urandom_range(0, 2)));
         total = len * rows * $urandom_range(1, 3);
         // Now and then the sweep is cut short and the next write restarts it.
         if ($urandom_range(0, 5) == 0) begin
            total = $urandom_range(1, len * rows - 1);
         end
         send_cells(total, cell_style_type'($urandom_range(0, 2)));
      end
   endtask

   initial begin
      foreach (line_above[i]) begin
         line_above[i]     = '0;
         line_two_above[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_cell_extremes();
      test_register_limits();
      test_back_pressure();
      test_restart_mid_sweep();
      test_random_sweeps();
      settle_block();
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
